// File: rtl/uaq_pkg.sv
// shared types, codes and constants of the user activity qualifier
package uaq_pkg;

  // default sizes handed to the top level parameters
  localparam int TIME_BITS_DEF  = 48;
  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;

  // configuration port
  localparam int CFG_IDX_BITS = 2;
  localparam int MS_BITS      = 20;
  localparam int US_BITS      = 30;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE_GAP    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVITY_RUN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_GAP     = 2'd2;

  // threshold reset values in microseconds
  localparam logic [US_BITS-1:0] NOISE_US_RST = 30'd1000000;
  localparam logic [US_BITS-1:0] RUN_US_RST   = 30'd2000000;
  localparam logic [US_BITS-1:0] IDLE_US_RST  = 30'd5000000;

  // event codes
  localparam int OP_BITS = 3;
  localparam logic [OP_BITS-1:0] OP_MOUSE  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_BUTTON = 3'd1;
  localparam logic [OP_BITS-1:0] OP_KEY    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_QUERY  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SUSP   = 3'd4;
  localparam logic [OP_BITS-1:0] OP_RESUME = 3'd5;

  // mouse time kept as whole seconds plus a microsecond remainder
  localparam int GAP_BITS  = 20;
  localparam int SECS_BITS = 33;
  localparam logic [GAP_BITS-1:0]  US_PER_S     = 20'd1000000;
  // largest 52-bit microsecond total split into seconds and remainder
  localparam logic [SECS_BITS-1:0] MT_MAX_SECS  = 33'd4503599627;
  localparam logic [GAP_BITS-1:0]  MT_MAX_REM   = 20'd370495;

  // activity state
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NOISE  = 2'd1,
    MODE_ACTIVE = 2'd2,
    MODE_SUSP   = 2'd3
  } mode_e;

  // top level sequencer
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_COMMIT
  } ctl_state_e;

  // distance unit sequencer
  typedef enum logic [1:0] {
    DP_IDLE,
    DP_MUL,
    DP_ROOT
  } dist_phase_e;

  // status from the distance unit
  typedef struct packed {
    logic busy;
    logic sense_ok;
  } dist_stat_t;

  // milliseconds to microseconds by shifts: x*1024 - x*16 - x*8
  function automatic logic [US_BITS-1:0] ms_to_us(input logic [MS_BITS-1:0] v);
    logic [US_BITS-1:0] w;
    w = US_BITS'(v);
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

endpackage

// File: rtl/uaq_tcmp.sv
// bit-serial time difference and compare against a threshold, lsb first
module uaq_tcmp (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic en_i,
  input  logic a_i,
  input  logic b_i,
  input  logic t_i,
  output logic diff_o,
  output logic gt_o,
  output logic lt_o
);

  logic borrow_q, borrow_d;
  logic gt_q, gt_d;
  logic lt_q, lt_d;

  // one bit of a - b modulo the word width
  assign diff_o   = a_i ^ b_i ^ borrow_q;
  assign borrow_d = (~a_i & b_i) | (~(a_i ^ b_i) & borrow_q);

  // the highest differing bit seen so far decides the order
  always_comb begin
    gt_d = gt_q;
    lt_d = lt_q;
    if (diff_o != t_i) begin
      gt_d = diff_o;
      lt_d = t_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b0;
      gt_q     <= 1'b0;
      lt_q     <= 1'b0;
    end else if (clear_i) begin
      borrow_q <= 1'b0;
      gt_q     <= 1'b0;
      lt_q     <= 1'b0;
    end else if (en_i) begin
      borrow_q <= borrow_d;
      gt_q     <= gt_d;
      lt_q     <= lt_d;
    end
  end

  assign gt_o = gt_q;
  assign lt_o = lt_q;

endmodule

// File: rtl/uaq_dist.sv
// euclidean distance: shift-add squares, then a two-bit-a-cycle square root
module uaq_dist import uaq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  output dist_stat_t                   stat_o,
  output logic [COORD_BITS:0]          root_o
);

  localparam int SW = 2 * COORD_BITS + 2;   // sum of squares, even width
  localparam int RMW = COORD_BITS + 3;      // partial remainder
  localparam int WW = COORD_BITS + 5;       // remainder with next digit
  localparam int CW = $clog2(COORD_BITS + 1);
  localparam logic [CW-1:0] MUL_LAST  = CW'(COORD_BITS - 1);
  localparam logic [CW-1:0] ROOT_LAST = CW'(COORD_BITS);

  dist_phase_e phase_q, phase_d;

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0] mag_x, mag_y;
  logic [COORD_BITS-1:0] ay_q;
  logic [COORD_BITS-1:0] mplier_q;
  logic [SW-1:0]         mcand_q;
  logic [SW-1:0]         acc_q, acc_nx;
  logic [SW-1:0]         rad_q;
  logic [RMW-1:0]        rem_q, rem_nx;
  logic [COORD_BITS:0]   root_q, root_nx;
  logic [WW-1:0]         work, trial;
  logic                  ge;
  logic [CW-1:0]         cnt_q;
  logic                  second_q;
  logic                  sense_q;
  logic                  mul_end, root_end;

  // coordinate deltas and magnitudes
  always_comb begin
    dx    = {a_x_i[COORD_BITS-1], a_x_i} - {b_x_i[COORD_BITS-1], b_x_i};
    dy    = {a_y_i[COORD_BITS-1], a_y_i} - {b_y_i[COORD_BITS-1], b_y_i};
    mag_x = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    mag_y = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  end

  // one partial product per cycle
  assign acc_nx = mplier_q[0] ? acc_q + mcand_q : acc_q;

  // one root digit per cycle
  always_comb begin
    work    = {rem_q, rad_q[SW-1:SW-2]};
    trial   = WW'({root_q, 2'b01});
    ge      = (work >= trial);
    rem_nx  = ge ? RMW'(work - trial) : RMW'(work);
    root_nx = {root_q[COORD_BITS-1:0], ge};
  end

  assign mul_end  = (cnt_q == MUL_LAST) && second_q;
  assign root_end = (cnt_q == ROOT_LAST);

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      DP_IDLE: if (start_i) phase_d = DP_MUL;
      DP_MUL:  if (mul_end) phase_d = DP_ROOT;
      DP_ROOT: if (root_end) phase_d = DP_IDLE;
      default: phase_d = DP_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    stat_o.busy     = (phase_q != DP_IDLE);
    stat_o.sense_ok = sense_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= DP_IDLE;
      cnt_q    <= '0;
      second_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == DP_IDLE) begin
        cnt_q    <= '0;
        second_q <= 1'b0;
      end else if (phase_q == DP_MUL && cnt_q == MUL_LAST) begin
        cnt_q    <= '0;
        second_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      DP_IDLE: begin
        if (start_i) begin
          ay_q     <= mag_y;
          mplier_q <= mag_x;
          mcand_q  <= SW'(mag_x);
          acc_q    <= '0;
          sense_q  <= (mag_x >= COORD_BITS'(3)) && (mag_y >= COORD_BITS'(3));
        end
      end
      DP_MUL: begin
        acc_q <= acc_nx;
        if (cnt_q == MUL_LAST && !second_q) begin
          mplier_q <= ay_q;
          mcand_q  <= SW'(ay_q);
        end else begin
          mplier_q <= mplier_q >> 1;
          mcand_q  <= mcand_q << 1;
        end
        if (mul_end) begin
          rad_q  <= acc_nx;
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      DP_ROOT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_nx;
        root_q <= root_nx;
      end
      default: begin
        rad_q <= rad_q;
      end
    endcase
  end

  assign root_o = root_q;

endmodule

// File: rtl/user_activity_qualifier.sv
// user activity qualifier: top level with sequencer, state and counters
//
// Each event is taken on the input channel and answered by one result with
// the activity state and the saturating counters as they stand after it.
// Event times are compared one bit a cycle, while the distance unit forms
// the squared distance by shift-add and its square root two bits a cycle;
// the two run side by side. One event is in work at a time, and the next
// event can be taken as soon as the result is posted. The output register
// lets the next event be taken while a result waits.
// Configuration writes are always ready; writing any threshold also sets the
// state to idle.
module user_activity_qualifier import uaq_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [MS_BITS-1:0]           cfg_data_i,
  // event channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [OP_BITS-1:0]           op_i,
  input  logic [TIME_BITS-1:0]         now_us_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic                         wheel_moved_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   activity_state_o,
  output logic [COUNT_BITS-1:0]        movement_total_o,
  output logic [COUNT_BITS-1:0]        click_travel_total_o,
  output logic [COUNT_BITS-1:0]        click_count_o,
  output logic [COUNT_BITS-1:0]        key_count_o,
  output logic [COUNT_BITS-1:0]        movement_seconds_o
);

  localparam int KW     = $clog2(TIME_BITS);
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int SUM_W  = ((COUNT_BITS > ROOT_W) ? COUNT_BITS : ROOT_W) + 1;
  localparam int SX     = (COUNT_BITS > SECS_BITS) ? COUNT_BITS : SECS_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [KW-1:0]         K_LAST   = KW'(TIME_BITS - 1);
  localparam logic [KW-1:0]         K_GAP    = KW'(GAP_BITS);
  localparam logic [TIME_BITS-1:0]  SEC_EXT  = TIME_BITS'(US_PER_S);

  // saturating counter add
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [ROOT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(CNT_MAX)) return CNT_MAX;
    return COUNT_BITS'(s);
  endfunction

  ctl_state_e cs_q, cs_d;

  // thresholds in microseconds
  logic [US_BITS-1:0] noise_us_q, run_us_q, idle_us_q;
  logic [TIME_BITS-1:0] noise_ext, run_ext, idle_ext;

  // captured event
  logic [OP_BITS-1:0]           op_q;
  logic [TIME_BITS-1:0]         now_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic                         wheel_q;

  // activity and usage state
  mode_e                        mode_q, mode_d;
  logic [TIME_BITS-1:0]         run_start_q, run_start_d;
  logic [TIME_BITS-1:0]         last_event_q, last_event_d;
  logic [TIME_BITS-1:0]         last_mouse_q, last_mouse_d;
  logic [GAP_BITS-1:0]          rem_q, rem_d;
  logic [SECS_BITS-1:0]         secs_q, secs_d;
  logic signed [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic signed [COORD_BITS-1:0] click_x_q, click_x_d, click_y_q, click_y_d;
  logic [COUNT_BITS-1:0]        move_q, move_d, travel_q, travel_d;
  logic [COUNT_BITS-1:0]        clicks_q, clicks_d, keys_q, keys_d;

  // serial time compare control
  logic [KW-1:0]       k_q;
  logic                bits_done_q;
  logic [GAP_BITS-1:0] gap_q;
  logic                cmp_en;
  logic                now_bit;
  logic                noise_gt, run_lt, idle_gt, mouse_lt, gap_bit;
  logic                unused_diff0, unused_diff1, unused_diff2;
  logic                unused_lt0, unused_gt1, unused_lt2, unused_gt3;

  // distance unit
  logic                         dist_start;
  logic signed [COORD_BITS-1:0] da_x, da_y;
  dist_stat_t                   dist_stat;
  logic [ROOT_W-1:0]            root;

  // handshakes
  logic in_fire, cfg_fire, cfg_hit, commit_en;
  logic out_valid_q;

  // commit-time values
  logic is_mouse, is_btn, is_key, is_query, is_susp, is_resume;
  logic counted, act, time_add;
  logic [GAP_BITS:0]    rem_sum;
  logic [GAP_BITS-1:0]  rem_t;
  logic [SECS_BITS-1:0] secs_t;
  logic [COUNT_BITS-1:0] secs_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;

  // configuration decode
  always_comb begin
    unique case (cfg_index_i) inside
      CFG_NOISE_GAP, CFG_ACTIVITY_RUN, CFG_IDLE_GAP: cfg_hit = cfg_fire;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_us_q <= NOISE_US_RST;
      run_us_q   <= RUN_US_RST;
      idle_us_q  <= IDLE_US_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_NOISE_GAP:    noise_us_q <= ms_to_us(cfg_data_i);
        CFG_ACTIVITY_RUN: run_us_q   <= ms_to_us(cfg_data_i);
        CFG_IDLE_GAP:     idle_us_q  <= ms_to_us(cfg_data_i);
        default:          noise_us_q <= noise_us_q;
      endcase
    end
  end

  assign noise_ext = TIME_BITS'(noise_us_q);
  assign run_ext   = TIME_BITS'(run_us_q);
  assign idle_ext  = TIME_BITS'(idle_us_q);

  // sequencer next state
  always_comb begin
    cs_d = cs_q;
    unique case (cs_q)
      CS_IDLE:   if (in_fire) cs_d = CS_RUN;
      CS_RUN:    if (bits_done_q && !dist_stat.busy) cs_d = CS_COMMIT;
      CS_COMMIT: if (!out_valid_q || out_ready_i) cs_d = CS_IDLE;
      default:   cs_d = CS_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = (cs_q == CS_IDLE);
    cmp_en     = (cs_q == CS_RUN) && !bits_done_q;
    commit_en  = (cs_q == CS_COMMIT) && (!out_valid_q || out_ready_i);
    dist_start = in_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q        <= CS_IDLE;
      k_q         <= '0;
      bits_done_q <= 1'b0;
    end else begin
      cs_q <= cs_d;
      if (in_fire) begin
        k_q         <= '0;
        bits_done_q <= 1'b0;
      end else if (cmp_en) begin
        k_q <= k_q + KW'(1);
        if (k_q == K_LAST) bits_done_q <= 1'b1;
      end
    end
  end

  // event capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_i;
      now_q   <= now_us_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      wheel_q <= wheel_moved_i;
    end
  end

  // low bits of the mouse gap, shifted in lsb first
  always_ff @(posedge clk_i) begin
    if (cmp_en && k_q < K_GAP) gap_q <= {gap_bit, gap_q[GAP_BITS-1:1]};
  end

  assign now_bit = now_q[k_q];

  // four time comparators fed one bit a cycle
  uaq_tcmp u_cmp_noise (
    .clk_i, .rst_ni, .clear_i(in_fire), .en_i(cmp_en),
    .a_i(now_bit), .b_i(last_event_q[k_q]), .t_i(noise_ext[k_q]),
    .diff_o(unused_diff0), .gt_o(noise_gt), .lt_o(unused_lt0)
  );

  uaq_tcmp u_cmp_run (
    .clk_i, .rst_ni, .clear_i(in_fire), .en_i(cmp_en),
    .a_i(now_bit), .b_i(run_start_q[k_q]), .t_i(run_ext[k_q]),
    .diff_o(unused_diff1), .gt_o(unused_gt1), .lt_o(run_lt)
  );

  uaq_tcmp u_cmp_idle (
    .clk_i, .rst_ni, .clear_i(in_fire), .en_i(cmp_en),
    .a_i(now_bit), .b_i(last_event_q[k_q]), .t_i(idle_ext[k_q]),
    .diff_o(unused_diff2), .gt_o(idle_gt), .lt_o(unused_lt2)
  );

  uaq_tcmp u_cmp_mouse (
    .clk_i, .rst_ni, .clear_i(in_fire), .en_i(cmp_en),
    .a_i(now_bit), .b_i(last_mouse_q[k_q]), .t_i(SEC_EXT[k_q]),
    .diff_o(gap_bit), .gt_o(unused_gt3), .lt_o(mouse_lt)
  );

  // distance operands: new position for a move, last click for a button
  always_comb begin
    da_x = (op_i == OP_BUTTON) ? click_x_q : pos_x_i;
    da_y = (op_i == OP_BUTTON) ? click_y_q : pos_y_i;
  end

  uaq_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i,
    .rst_ni,
    .start_i(dist_start),
    .a_x_i(da_x),
    .a_y_i(da_y),
    .b_x_i(last_x_q),
    .b_y_i(last_y_q),
    .stat_o(dist_stat),
    .root_o(root)
  );

  // event decode
  always_comb begin
    is_mouse  = (op_q == OP_MOUSE);
    is_btn    = (op_q == OP_BUTTON);
    is_key    = (op_q == OP_KEY);
    is_query  = (op_q == OP_QUERY);
    is_susp   = (op_q == OP_SUSP);
    is_resume = (op_q == OP_RESUME);
    counted   = is_mouse && (dist_stat.sense_ok || wheel_q);
    act       = counted || is_btn || is_key;
    time_add  = counted && (|last_mouse_q) && mouse_lt;
  end

  // activity state update
  always_comb begin
    mode_d       = mode_q;
    run_start_d  = run_start_q;
    last_event_d = last_event_q;
    if (commit_en) begin
      if (act) begin
        if (mode_q == MODE_IDLE) begin
          run_start_d = now_q;
          mode_d      = (run_us_q == '0) ? MODE_ACTIVE : MODE_NOISE;
        end else if (mode_q == MODE_NOISE) begin
          if (noise_gt) run_start_d = now_q;
          else if (!run_lt) mode_d = MODE_ACTIVE;
        end
        last_event_d = now_q;
      end else if (is_query) begin
        if (mode_q == MODE_ACTIVE && idle_gt) mode_d = MODE_IDLE;
      end else if (is_susp) begin
        mode_d = MODE_SUSP;
      end else if (is_resume) begin
        mode_d = MODE_IDLE;
      end
    end
    if (cfg_hit) mode_d = MODE_IDLE;
  end

  // mouse time: seconds and remainder, clamped to the 52-bit total
  always_comb begin
    rem_sum = {1'b0, rem_q} + {1'b0, gap_q};
    if (rem_sum >= {1'b0, US_PER_S}) begin
      rem_t  = GAP_BITS'(rem_sum - {1'b0, US_PER_S});
      secs_t = secs_q + SECS_BITS'(1);
    end else begin
      rem_t  = GAP_BITS'(rem_sum);
      secs_t = secs_q;
    end
    if (secs_t > MT_MAX_SECS || (secs_t == MT_MAX_SECS && rem_t > MT_MAX_REM)) begin
      secs_t = MT_MAX_SECS;
      rem_t  = MT_MAX_REM;
    end
    rem_d  = rem_q;
    secs_d = secs_q;
    if (commit_en && time_add) begin
      rem_d  = rem_t;
      secs_d = secs_t;
    end
    secs_out = (SX'(secs_d) > SX'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(secs_d);
  end

  // positions and counters
  always_comb begin
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    last_mouse_d = last_mouse_q;
    click_x_d    = click_x_q;
    click_y_d    = click_y_q;
    move_d       = move_q;
    travel_d     = travel_q;
    clicks_d     = clicks_q;
    keys_d       = keys_q;
    if (commit_en) begin
      if (counted) begin
        move_d       = sat_add(move_q, root);
        last_x_d     = px_q;
        last_y_d     = py_q;
        last_mouse_d = now_q;
      end
      if (is_btn) begin
        // a stored x of all ones means no click yet
        if (click_x_q != '1) travel_d = sat_add(travel_q, root);
        click_x_d = last_x_q;
        click_y_d = last_y_q;
        clicks_d  = sat_add(clicks_q, ROOT_W'(1));
      end
      if (is_key) keys_d = sat_add(keys_q, ROOT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      run_start_q  <= '0;
      last_event_q <= '0;
      last_mouse_q <= '0;
      rem_q        <= '0;
      secs_q       <= '0;
      last_x_q     <= '1;
      last_y_q     <= '1;
      click_x_q    <= '1;
      click_y_q    <= '1;
      move_q       <= '0;
      travel_q     <= '0;
      clicks_q     <= '0;
      keys_q       <= '0;
    end else begin
      mode_q       <= mode_d;
      run_start_q  <= run_start_d;
      last_event_q <= last_event_d;
      last_mouse_q <= last_mouse_d;
      rem_q        <= rem_d;
      secs_q       <= secs_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      click_x_q    <= click_x_d;
      click_y_q    <= click_y_d;
      move_q       <= move_d;
      travel_q     <= travel_d;
      clicks_q     <= clicks_d;
      keys_q       <= keys_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_en) begin
      activity_state_o     <= mode_d;
      movement_total_o     <= move_d;
      click_travel_total_o <= travel_d;
      click_count_o        <= clicks_d;
      key_count_o          <= keys_d;
      movement_seconds_o   <= secs_out;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/uaq_checker.sv
// port-level checks of the user activity qualifier and their bind
module uaq_checker import uaq_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [1:0]            activity_state_o,
  input logic [COUNT_BITS-1:0] movement_total_o,
  input logic [COUNT_BITS-1:0] click_travel_total_o,
  input logic [COUNT_BITS-1:0] click_count_o,
  input logic [COUNT_BITS-1:0] key_count_o,
  input logic [COUNT_BITS-1:0] movement_seconds_o
);

  // an accepted event keeps the block busy on the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an input transfer");

  // a new result appears only from a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

  // the block is ready for the next event as soon as a result is posted
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("input not ready when a result was posted");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(activity_state_o) &&
      $stable(movement_total_o) && $stable(click_travel_total_o) &&
      $stable(click_count_o) && $stable(key_count_o) && $stable(movement_seconds_o))
    else $error("stalled result changed");

endmodule

bind user_activity_qualifier uaq_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_uaq_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .activity_state_o(activity_state_o),
  .movement_total_o(movement_total_o),
  .click_travel_total_o(click_travel_total_o),
  .click_count_o(click_count_o),
  .key_count_o(key_count_o),
  .movement_seconds_o(movement_seconds_o)
);
